### rtl/observation_line_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// Observation line parser assertion macros
// Shared concurrent assertion forms, clocked on aclk, with checks held off
// while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef OBSERVATION_LINE_PARSER_UNIT_MACROS_SVH
`define OBSERVATION_LINE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication.
`define OLP_ASSERT_NOW(label, cond, conseq) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (conseq)) else $error("olp assertion failed");

// Next-cycle implication.
`define OLP_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (conseq)) else $error("olp assertion failed");

`endif

### rtl/olp_pkg.sv
// ----------------------------------------------------------------------------
// Observation line parser package
// Payload types, phase encoding, result codes and the fixed literals.
// ----------------------------------------------------------------------------
`default_nettype none

package olp_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_line;
    } olp_in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         data;
        logic signed [31:0] exit_value;
        logic [1:0]         status;
        logic               last;
    } olp_out_t;

    typedef enum logic [3:0] {
        PH_PREFIX,
        PH_TOOLLIT,
        PH_NAME,
        PH_EXITLIT,
        PH_SIGN,
        PH_FIRSTDIG,
        PH_DIGITS,
        PH_OUTLIT,
        PH_TEXT,
        PH_ESC,
        PH_CLOSED,
        PH_FAILED
    } olp_phase_t;

    // Per-line parse context that does not depend on the length bounds.
    typedef struct packed {
        olp_phase_t  phase;
        logic [3:0]  literal_index;
        logic [31:0] exit_magnitude;
        logic        exit_negative;
        logic [1:0]  fail_code;
    } olp_ctx_t;

    localparam logic [1:0] KIND_TOOL   = 2'd0;
    localparam logic [1:0] KIND_OUT    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TOOLONG   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [35:0] MAG_LIMIT = 36'd2147483647;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;

    localparam logic [8*13-1:0] LIT_PREFIX = "OBSERVATION: ";
    localparam logic [8*5-1:0]  LIT_TOOL   = "TOOL=";
    localparam logic [8*5-1:0]  LIT_EXIT   = "EXIT=";
    localparam logic [8*5-1:0]  LIT_OUT    = "OUT=\"";

    // Expected byte at position idx of the literal that the phase matches.
    function automatic logic [7:0] lit_byte(input olp_phase_t ph, input logic [3:0] idx);
        logic [7:0] b;
        b = CH_NUL;
        case (ph)
            PH_PREFIX: begin
                if (idx < 4'd13) b = LIT_PREFIX[8*(12 - int'(idx)) +: 8];
            end
            PH_TOOLLIT: begin
                if (idx < 4'd5) b = LIT_TOOL[8*(4 - int'(idx)) +: 8];
            end
            PH_EXITLIT: begin
                if (idx < 4'd5) b = LIT_EXIT[8*(4 - int'(idx)) +: 8];
            end
            PH_OUTLIT: begin
                if (idx < 4'd5) b = LIT_OUT[8*(4 - int'(idx)) +: 8];
            end
            default: b = CH_NUL;
        endcase
        return b;
    endfunction

    // Index of the final byte of the literal that the phase matches.
    function automatic logic [3:0] lit_last(input olp_phase_t ph);
        logic [3:0] n;
        case (ph)
            PH_PREFIX: n = 4'd12;
            default:   n = 4'd4;
        endcase
        return n;
    endfunction

    // Phase that follows a fully matched literal.
    function automatic olp_phase_t lit_next(input olp_phase_t ph);
        olp_phase_t n;
        case (ph)
            PH_PREFIX:  n = PH_TOOLLIT;
            PH_TOOLLIT: n = PH_NAME;
            PH_EXITLIT: n = PH_SIGN;
            PH_OUTLIT:  n = PH_TEXT;
            default:    n = PH_FAILED;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/olp_step.sv
// ----------------------------------------------------------------------------
// Observation line parser step logic
// Combinational next-state and result for one byte of the line.
// ----------------------------------------------------------------------------
`default_nettype none

module olp_step
    import olp_pkg::*;
#(
    parameter int TOOL_MAX = 64,
    parameter int OUT_MAX  = 4096,
    localparam int TOOL_W  = $clog2(TOOL_MAX),
    localparam int OUT_W   = $clog2(OUT_MAX)
) (
    input  wire olp_ctx_t          ctx,
    input  wire logic [TOOL_W-1:0] tool_count,
    input  wire logic [OUT_W-1:0]  out_count,
    input  wire olp_in_t           item,
    output olp_ctx_t               ctx_next,
    output logic [TOOL_W-1:0]      tool_count_next,
    output logic [OUT_W-1:0]       out_count_next,
    output logic                   res_valid,
    output olp_out_t               res
);

    logic [7:0]  c;
    logic        eol;
    logic        is_digit;
    logic [35:0] mag_x10;
    logic        digit_ovf;
    logic        lit_hit;
    logic        lit_done;
    logic        tool_full;
    logic        out_full;
    logic [1:0]  eol_status;

    assign c         = item.char_in;
    assign eol       = item.end_of_line || (c == CH_NUL);
    assign is_digit  = (c inside {[CH_ZERO:CH_NINE]});
    // Shift-and-add times ten plus the new digit; overflow past the 31-bit limit.
    assign mag_x10   = ({4'b0, ctx.exit_magnitude} << 3) + ({4'b0, ctx.exit_magnitude} << 1)
                     + {32'b0, c[3:0]};
    assign digit_ovf = mag_x10 > MAG_LIMIT;
    assign lit_hit   = c == lit_byte(ctx.phase, ctx.literal_index);
    assign lit_done  = ctx.literal_index == lit_last(ctx.phase);
    assign tool_full = tool_count >= TOOL_W'(TOOL_MAX - 1);
    assign out_full  = out_count >= OUT_W'(OUT_MAX - 1);

    always_comb begin
        if (ctx.fail_code != ST_OK) begin
            eol_status = ctx.fail_code;
        end else if (ctx.phase == PH_CLOSED) begin
            eol_status = ST_OK;
        end else begin
            eol_status = ST_MALFORMED;
        end
    end

    always_comb begin
        ctx_next        = ctx;
        tool_count_next = tool_count;
        out_count_next  = out_count;
        res_valid       = 1'b0;
        res             = '0;

        if (eol) begin
            ctx_next        = '{phase: PH_PREFIX, default: '0};
            tool_count_next = '0;
            out_count_next  = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_STATUS;
            res.status      = eol_status;
            res.last        = 1'b1;
            if (eol_status == ST_OK) begin
                res.exit_value = ctx.exit_negative ? -$signed(ctx.exit_magnitude)
                                                   : $signed(ctx.exit_magnitude);
            end
        end else begin
            case (ctx.phase)
                PH_PREFIX, PH_TOOLLIT, PH_EXITLIT, PH_OUTLIT: begin
                    if (!lit_hit) begin
                        ctx_next.phase     = PH_FAILED;
                        ctx_next.fail_code = ST_MALFORMED;
                    end else if (lit_done) begin
                        ctx_next.literal_index = '0;
                        ctx_next.phase         = lit_next(ctx.phase);
                    end else begin
                        ctx_next.literal_index = ctx.literal_index + 4'd1;
                    end
                end
                PH_NAME: begin
                    if (c == CH_SPACE) begin
                        ctx_next.phase = PH_EXITLIT;
                    end else if (tool_full) begin
                        ctx_next.phase     = PH_FAILED;
                        ctx_next.fail_code = ST_TOOLONG;
                    end else begin
                        tool_count_next = tool_count + TOOL_W'(1);
                        res_valid       = 1'b1;
                        res.kind        = KIND_TOOL;
                        res.data        = c;
                    end
                end
                PH_SIGN, PH_FIRSTDIG, PH_DIGITS: begin
                    if (is_digit) begin
                        if (digit_ovf) begin
                            ctx_next.phase     = PH_FAILED;
                            ctx_next.fail_code = ST_OVERFLOW;
                        end else begin
                            ctx_next.phase          = PH_DIGITS;
                            ctx_next.exit_magnitude = mag_x10[31:0];
                        end
                    end else if (ctx.phase == PH_SIGN && c == CH_MINUS) begin
                        ctx_next.exit_negative = 1'b1;
                        ctx_next.phase         = PH_FIRSTDIG;
                    end else if (ctx.phase == PH_DIGITS && c == CH_SPACE) begin
                        ctx_next.phase = PH_OUTLIT;
                    end else begin
                        ctx_next.phase     = PH_FAILED;
                        ctx_next.fail_code = ST_MALFORMED;
                    end
                end
                PH_TEXT: begin
                    if (c == CH_QUOTE) begin
                        ctx_next.phase = PH_CLOSED;
                    end else if (out_full) begin
                        ctx_next.phase     = PH_FAILED;
                        ctx_next.fail_code = ST_TOOLONG;
                    end else if (c == CH_BACKSLASH) begin
                        ctx_next.phase = PH_ESC;
                    end else begin
                        out_count_next = out_count + OUT_W'(1);
                        res_valid      = 1'b1;
                        res.kind       = KIND_OUT;
                        res.data       = c;
                    end
                end
                PH_ESC: begin
                    ctx_next.phase = PH_TEXT;
                    out_count_next = out_count + OUT_W'(1);
                    res_valid      = 1'b1;
                    res.kind       = KIND_OUT;
                    case (c)
                        CH_LOWER_N:             res.data = CH_LF;
                        CH_LOWER_R:             res.data = CH_CR;
                        CH_LOWER_T:             res.data = CH_TAB;
                        CH_BACKSLASH, CH_QUOTE: res.data = c;
                        default: begin
                            ctx_next.phase     = PH_FAILED;
                            ctx_next.fail_code = ST_MALFORMED;
                            out_count_next     = out_count;
                            res_valid          = 1'b0;
                            res                = '0;
                        end
                    endcase
                end
                PH_CLOSED: begin
                    ctx_next.phase     = PH_FAILED;
                    ctx_next.fail_code = ST_MALFORMED;
                end
                default: begin
                    // Failed line: swallow bytes until the end of the line.
                    if (ctx.fail_code == ST_OK) begin
                        ctx_next.phase     = PH_FAILED;
                        ctx_next.fail_code = ST_MALFORMED;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/observation_line_parser_unit.sv
// ----------------------------------------------------------------------------
// Observation line parser unit
// Path: a byte is held in the input register, its result in the result register.
// Throughput: one byte per cycle while m_ready does not hold the result register.
// Reset: synchronous active-low aresetn empties both registers and the context.
// ----------------------------------------------------------------------------
`default_nettype none
`include "observation_line_parser_unit_macros.svh"

module observation_line_parser_unit
    import olp_pkg::*;
#(
    parameter int TOOL_MAX = 64,
    parameter int OUT_MAX  = 4096
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire olp_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output olp_out_t     m_data
);

    localparam int TOOL_W = $clog2(TOOL_MAX);
    localparam int OUT_W  = $clog2(OUT_MAX);

    // The input register holds one request. It advances into the parse step
    // whenever the result register is empty or is being drained in the same
    // cycle, so a new byte can enter every cycle while results flow out.
    logic              in_valid_reg;
    olp_in_t           in_item_reg;

    // Parse context for the line currently being read.
    olp_ctx_t          ctx_reg;
    olp_ctx_t          ctx_next;
    logic [TOOL_W-1:0] tool_count_reg;
    logic [TOOL_W-1:0] tool_count_next;
    logic [OUT_W-1:0]  out_count_reg;
    logic [OUT_W-1:0]  out_count_next;

    // Result register toward the m_ channel.
    logic              out_valid_reg;
    olp_out_t          out_item_reg;

    logic              step_res_valid;
    olp_out_t          step_res;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    olp_step #(
        .TOOL_MAX (TOOL_MAX),
        .OUT_MAX  (OUT_MAX)
    ) u_step (
        .ctx             (ctx_reg),
        .tool_count      (tool_count_reg),
        .out_count       (out_count_reg),
        .item            (in_item_reg),
        .ctx_next        (ctx_next),
        .tool_count_next (tool_count_next),
        .out_count_next  (out_count_next),
        .res_valid       (step_res_valid),
        .res             (step_res)
    );

    // Control state: request valid flags and the parse context.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            ctx_reg        <= '{phase: PH_PREFIX, default: '0};
            tool_count_reg <= '0;
            out_count_reg  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                ctx_reg        <= ctx_next;
                tool_count_reg <= tool_count_next;
                out_count_reg  <= out_count_next;
                out_valid_reg  <= step_res_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance && step_res_valid) begin
            out_item_reg <= step_res;
        end
    end

    // A pending result always leaves room for a new request when nothing waits.
    `OLP_ASSERT_NOW(a_ready_when_empty, !in_valid_reg, s_ready)
    // Status results, and only they, close a line.
    `OLP_ASSERT_NOW(a_last_is_status, out_valid_reg,
        out_item_reg.last == (out_item_reg.kind == KIND_STATUS))
    // Byte results carry no exit code and no status.
    `OLP_ASSERT_NOW(a_byte_clean, out_valid_reg && !out_item_reg.last,
        out_item_reg.exit_value == 32'sd0 && out_item_reg.status == ST_OK)
    // Closing a line leaves the context back at its reset values.
    `OLP_ASSERT_NEXT(a_line_restart, advance && step_res_valid && step_res.last,
        ctx_reg.phase == PH_PREFIX && tool_count_reg == '0 && out_count_reg == '0
        && ctx_reg.fail_code == ST_OK)
    // A failed line never yields a byte result afterward.
    `OLP_ASSERT_NOW(a_failed_silent, advance && ctx_reg.phase == PH_FAILED && step_res_valid,
        step_res.last)

endmodule

`default_nettype wire
